// ----- rtl/owbf_pkg.sv -----
// ----------------------------------------------------------------------------
// owbf_pkg
// Shared types and constants for the overwrite-oldest byte FIFO.
// ----------------------------------------------------------------------------
package owbf_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int LEVEL_W   = 7;
    localparam int CNT_W     = 32;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_DRAIN = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               has_data;
        logic               last;
        logic [LEVEL_W-1:0] level;
        logic [CNT_W-1:0]   dropped_total;
    } out_t;

    typedef struct packed {
        logic       is_write;
        logic       is_drain;
        logic       is_clear;
        logic [7:0] data_byte;
    } cmd_t;

endpackage

// ----- rtl/owbf_front.sv -----
// ----------------------------------------------------------------------------
// owbf_front
// Accepts requests, decodes them into commands and holds them in a short
// queue for the back end.
// ----------------------------------------------------------------------------
module owbf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  owbf_pkg::in_t   req_data,
    output logic            cmd_valid,
    input  logic            cmd_pop,
    output owbf_pkg::cmd_t  cmd
);
    import owbf_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t            queue_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    cmd_t            dec;
    logic            push;
    logic            pop;

    always_comb
    begin
        dec           = '0;
        dec.data_byte = req_data.data_byte;
        case (req_data.req_type)
            REQ_WRITE: dec.is_write = 1'b1;
            REQ_DRAIN: dec.is_drain = 1'b1;
            REQ_CLEAR: dec.is_clear = 1'b1;
            default:   dec          = '0;
        endcase
    end

    assign req_ready = (count_reg != CW'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- rtl/owbf_back.sv -----
// ----------------------------------------------------------------------------
// owbf_back
// Executes commands against the ring buffer: stores bytes, streams drains
// through a registered read, and drives the result register.
// ----------------------------------------------------------------------------
module owbf_back #(
    parameter int DEPTH = owbf_pkg::DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    input  owbf_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output owbf_pkg::out_t  res_data
);
    import owbf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    logic [7:0]        mem [DEPTH];
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [LW-1:0]     level_reg;
    logic [LW-1:0]     level_next;
    logic [CNT_W-1:0]  drop_reg;
    logic [CNT_W-1:0]  drop_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [LW-1:0]     remain_reg;
    logic [LW-1:0]     remain_next;
    logic              pend_reg;
    logic              pend_next;
    logic              pend_last_reg;
    logic              pend_last_next;
    logic [7:0]        rdata_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_reg;
    out_t              out_next;
    logic              out_free;
    logic              draining;
    logic              pend_move;
    logic              issue;
    logic              take;
    logic              emit;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] r;
        r = (s >= DEPTH_S) ? s - DEPTH_S : s;
        return r[AW-1:0];
    endfunction

    assign out_free  = !out_valid_reg || res_ready;
    assign draining  = (remain_reg != '0);
    assign pend_move = pend_reg && out_free;
    assign issue     = draining && (!pend_reg || out_free);
    assign take      = cmd_valid && !draining && !pend_reg && out_free;
    assign cmd_pop   = take;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    always_comb
    begin
        head_next      = head_reg;
        level_next     = level_reg;
        drop_next      = drop_reg;
        rd_ptr_next    = rd_ptr_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = wrap({1'b0, head_reg} + (AW + 1)'(level_reg));
        emit           = 1'b0;

        if (issue)
        begin
            rd_ptr_next    = wrap({1'b0, rd_ptr_reg} + 1'b1);
            remain_next    = remain_reg - 1'b1;
            pend_next      = 1'b1;
            pend_last_next = (remain_reg == LW'(1));
        end
        else if (pend_move)
        begin
            pend_next = 1'b0;
        end

        if (take)
        begin
            if (cmd.is_write)
            begin
                mem_we = 1'b1;
                emit   = 1'b1;
                if (level_reg == DEPTH_L)
                begin
                    mem_waddr = head_reg;
                    head_next = wrap({1'b0, head_reg} + 1'b1);
                    if (drop_reg != '1)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                end
                else
                begin
                    level_next = level_reg + 1'b1;
                end
            end
            else if (cmd.is_drain)
            begin
                if (level_reg == '0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    rd_ptr_next = head_reg;
                    remain_next = level_reg;
                    head_next   = wrap({1'b0, head_reg} + (AW + 1)'(level_reg));
                    level_next  = '0;
                end
            end
            else if (cmd.is_clear)
            begin
                emit       = 1'b1;
                head_next  = '0;
                level_next = '0;
                drop_next  = '0;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        if (pend_move)
        begin
            out_valid_next         = 1'b1;
            out_next.out_byte      = rdata_reg;
            out_next.has_data      = 1'b1;
            out_next.last          = pend_last_reg;
            out_next.level         = '0;
            out_next.dropped_total = drop_reg;
        end
        else if (emit)
        begin
            out_valid_next         = 1'b1;
            out_next.out_byte      = '0;
            out_next.has_data      = 1'b0;
            out_next.last          = 1'b1;
            out_next.level         = LEVEL_W'(level_next);
            out_next.dropped_total = drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            level_reg     <= '0;
            drop_reg      <= '0;
            rd_ptr_reg    <= '0;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            level_reg     <= level_next;
            drop_reg      <= drop_next;
            rd_ptr_reg    <= rd_ptr_next;
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.data_byte;
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

// ----- rtl/overwrite_oldest_byte_fifo.sv -----
// ----------------------------------------------------------------------------
// Path: a write, clear or empty drain result passes the front queue and the
// result register; a drained byte also passes the registered memory read.
// Throughput: one write or clear per cycle, one drained byte per cycle from
// the single read port, each while res_ready holds; a drain blocks new commands.
// Reset: rst_n empties the buffer and zeroes head and drop count at once.
// ----------------------------------------------------------------------------
// overwrite_oldest_byte_fifo
// Byte ring buffer that overwrites the oldest entry when full and reports
// level and a saturating drop count with every result.
// ----------------------------------------------------------------------------
module overwrite_oldest_byte_fifo #(
    parameter int DEPTH = owbf_pkg::DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  owbf_pkg::in_t   req_data,
    output logic            res_valid,
    input  logic            res_ready,
    output owbf_pkg::out_t  res_data
);
    import owbf_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    owbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    owbf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

// ----- dv/overwrite_oldest_byte_fifo_test.sv -----
// ----------------------------------------------------------------------------
// overwrite_oldest_byte_fifo_test
// Self-checking test of the overwrite-oldest byte FIFO. Requests go in over a
// valid/ready channel and a local model of the ring (head, level, saturating
// drop count) predicts every result. Each returned result is compared field by
// field against the oldest prediction. The test covers directed corner cases,
// overflow while the result side is held off, and random write bursts with
// drains, clears and the spare request code. Both sides idle at random at first.
// ----------------------------------------------------------------------------
module overwrite_oldest_byte_fifo_test;

    timeunit 1ns;
    timeprecision 1ps;

    import owbf_pkg::*;

    localparam int         DEPTH         = DEPTH_DEF;
    localparam logic [1:0] REQ_SPARE     = 2'd3;
    localparam int         QUIET_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         REPORT_MAX    = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    in_t  req_data;
    logic res_valid;
    logic res_ready;
    out_t res_data;

    logic [7:0]         ring_bytes [DEPTH];
    logic [5:0]         ring_head  = '0;
    logic [LEVEL_W-1:0] ring_fill  = '0;
    logic [CNT_W-1:0]   ring_drops = '0;
    out_t               expected_results [$];

    int mismatch_count = 0;
    int hold_request   = 0;
    bit req_gaps_on    = 1'b1;
    bit res_stalls_on  = 1'b1;

    overwrite_oldest_byte_fifo i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    function automatic out_t fifo_status();
        out_t r;
        r.out_byte      = 8'h00;
        r.has_data      = 1'b0;
        r.last          = 1'b1;
        r.level         = ring_fill;
        r.dropped_total = ring_drops;
        return r;
    endfunction

    function automatic void predict_fifo_results(in_t req);
        int   count;
        int   start;
        out_t r;
        if (req.req_type == REQ_WRITE)
        begin
            if (ring_fill >= DEPTH)
            begin
                ring_head = 6'((int'(ring_head) + 1) % DEPTH);
                ring_fill = LEVEL_W'(DEPTH - 1);
                if (ring_drops != '1)
                    ring_drops = ring_drops + 1'b1;
            end
            ring_bytes[(int'(ring_head) + int'(ring_fill)) % DEPTH] = req.data_byte;
            ring_fill = ring_fill + 1'b1;
            expected_results.push_back(fifo_status());
        end
        else if (req.req_type == REQ_DRAIN)
        begin
            count = (ring_fill > DEPTH) ? DEPTH : int'(ring_fill);
            start = int'(ring_head);
            ring_head = 6'((start + count) % DEPTH);
            ring_fill = '0;
            if (count == 0)
                expected_results.push_back(fifo_status());
            for (int i = 0; i < count; i++)
            begin
                r.out_byte      = ring_bytes[(start + i) % DEPTH];
                r.has_data      = 1'b1;
                r.last          = (i == count - 1);
                r.level         = '0;
                r.dropped_total = ring_drops;
                expected_results.push_back(r);
            end
        end
        else
        begin
            if (req.req_type == REQ_CLEAR)
            begin
                ring_head  = '0;
                ring_fill  = '0;
                ring_drops = '0;
            end
            expected_results.push_back(fifo_status());
        end
    endfunction

    function automatic void report_mismatch(string what, out_t want, out_t got);
        if (mismatch_count < REPORT_MAX)
        begin
            $display("mismatch (%s) at %0t: expected byte %h data %b last %b level %0d drops %0d",
                     what, $realtime, want.out_byte, want.has_data, want.last, want.level,
                     want.dropped_total);
            $display("    actual byte %h data %b last %b level %0d drops %0d",
                     got.out_byte, got.has_data, got.last, got.level, got.dropped_total);
        end
        mismatch_count++;
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [7:0] value);
        in_t item;
        item.req_type  = kind;
        item.data_byte = value;
        if (req_gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_fifo_results(item);
    endtask

    task automatic wait_results_done();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic test_directed();
        send_request(REQ_WRITE, 8'h00);
        send_request(REQ_WRITE, 8'hFF);
        send_request(REQ_WRITE, 8'h5A);
        send_request(REQ_DRAIN, 8'hFF);
        send_request(REQ_DRAIN, 8'h00);
        send_request(REQ_WRITE, 8'h81);
        send_request(REQ_SPARE, 8'hFF);
        send_request(REQ_DRAIN, 8'h55);
        send_request(REQ_WRITE, 8'h01);
        send_request(REQ_WRITE, 8'h7E);
        send_request(REQ_CLEAR, 8'hAA);
        send_request(REQ_DRAIN, 8'h00);
        send_request(REQ_SPARE, 8'h00);
        send_request(REQ_CLEAR, 8'hFF);
        wait_results_done();
    endtask

    task automatic test_overflow_under_backpressure();
        hold_request = HOLD_CYCLES;
        repeat (DEPTH + 16)
            send_request(REQ_WRITE, 8'($urandom_range(0, 255)));
        send_request(REQ_DRAIN, 8'($urandom_range(0, 255)));
        send_request(REQ_WRITE, 8'($urandom_range(0, 255)));
        repeat (DEPTH + 3)
            send_request(REQ_WRITE, 8'($urandom_range(0, 255)));
        send_request(REQ_DRAIN, 8'($urandom_range(0, 255)));
        send_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int item_count);
        int sent;
        int burst;
        int pick;
        sent = 0;
        while (sent < item_count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 90)
                                                    : $urandom_range(0, 12);
                repeat (burst)
                    send_request(REQ_WRITE, 8'($urandom_range(0, 255)));
                send_request(REQ_DRAIN, 8'($urandom_range(0, 255)));
                sent += burst + 1;
            end
            else
            begin
                if (pick < 16)
                    send_request(REQ_CLEAR, 8'($urandom_range(0, 255)));
                else if (pick < 18)
                    send_request(REQ_SPARE, 8'($urandom_range(0, 255)));
                else
                    send_request(REQ_DRAIN, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else if (res_stalls_on && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                want = '0;
                report_mismatch("no request pending", want, res_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data.out_byte !== want.out_byte ||
                    res_data.has_data !== want.has_data ||
                    res_data.last !== want.last ||
                    res_data.level !== want.level ||
                    res_data.dropped_total !== want.dropped_total)
                    report_mismatch("field", want, res_data);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow_under_backpressure();
        test_random_traffic(50);
        req_gaps_on   = 1'b0;
        res_stalls_on = 1'b0;
        test_random_traffic(25);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
